[rtl/rational_arith_reduce_core_defines.svh]
// Assertion macros shared by the rational arithmetic RTL.
`ifndef RATIONAL_ARITH_REDUCE_CORE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RAR_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RAR_ASSERT(label, clk, rst_n, prop, msg)
`define RAR_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/rar_pkg.sv]
// Shared types and constants for the rational arithmetic block.
`default_nettype none
package rar_pkg;
	localparam int unsigned OperandWidthDefault = 16;
	localparam int unsigned OutWidth = 33;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G1,
		ST_K1,
		ST_K2,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_SUM,
		ST_G2,
		ST_Q1,
		ST_Q2,
		ST_DONE
	} state_t;

	// Command and status between the sequencer and the shared divider.
	typedef struct packed {
		logic start;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;
endpackage
`default_nettype wire

[rtl/rar_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
`include "rational_arith_reduce_core_defines.svh"
module rar_divider import rar_pkg::*; #(
	parameter int unsigned W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire div_cmd_t     cmd,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output div_sts_t          sts,
	output logic      [W-1:0] quotient,
	output logic      [W-1:0] remainder
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		trial   = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`RAR_ASSERT(a_no_start_busy, clk, arst_n, cmd.start |-> !busy_q, "divider started while busy")
	`RAR_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q), "done without busy")
	`RAR_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q, "done held longer than a cycle")
endmodule
`default_nettype wire

[rtl/rational_arith_reduce_core.sv]
// Top level of the rational arithmetic and GCD reduction block.
// Usage: present kind and two fractions first_num/first_den and
// second_num/second_den on the input channel with in_valid; a transaction
// takes place on a rising edge where in_valid is high and in_stall is low.
// The block then raises in_stall until its result has been taken.
// The result transaction carries result_num, result_den and zero_divisor,
// and completes on an edge where out_valid is high and out_stall is low.
// Sharing: a single bit-serial divider of 2*OPERAND_WIDTH+1 bits is shared
// for every modulo and quotient. Every operation with nonzero operand
// denominators runs the GCD steps of the first Euclid loop and two scale
// factor passes, then the products; unless the result denominator is zero,
// it then runs the second Euclid loop and two final quotient passes.
// A zero operand denominator presents its result on the
// cycle after acceptance. Only one transaction is in flight at a time.
// Reset clears the sequencer and output valid; nothing else needs clearing.
// While the receiver stalls, the result is held stable and no new input
// transaction is taken.
// Zero denominators (operand or result) give 0/1 with zero_divisor set.
// The result denominator sign is not normalised.
`default_nettype none
`include "rational_arith_reduce_core_defines.svh"
module rational_arith_reduce_core import rar_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      kind,
	input  wire logic signed [OPERAND_WIDTH-1:0] first_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] first_den,
	input  wire logic signed [OPERAND_WIDTH-1:0] second_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] second_den,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [OutWidth-1:0]           result_num,
	output logic signed [OutWidth-1:0]           result_den,
	output logic                                 zero_divisor
);
	// Products of two operands need 2W bits; the sum one more.
	localparam int unsigned PW = 2 * OPERAND_WIDTH + 1;

	state_t state_q, state_d;
	kind_t  kind_q;
	logic signed [OPERAND_WIDTH-1:0] n1_q, d1_q, n2_q, d2_q;
	// General registers: Euclid pair, then scaled values.
	logic [PW-1:0] a_q, b_q;
	logic [PW-1:0] k1_q, k2_q;
	logic signed [PW-1:0] rn_q, rd_q, t_q;
	logic [PW-1:0] mn_q, md_q;

	div_cmd_t      dcmd;
	div_sts_t      dsts;
	logic [PW-1:0] div_a, div_b, quo, rem;

	logic signed [PW-1:0] mul_a, mul_b;
	logic [PW-1:0]        abs_d1, abs_d2;

	rar_divider #(.W(PW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dcmd),
		.dividend  (div_a),
		.divisor   (div_b),
		.sts       (dsts),
		.quotient  (quo),
		.remainder (rem)
	);

	assign abs_d1 = d1_q[OPERAND_WIDTH-1] ? PW'(-PW'(d1_q)) : PW'($unsigned(d1_q));
	assign abs_d2 = d2_q[OPERAND_WIDTH-1] ? PW'(-PW'(d2_q)) : PW'($unsigned(d2_q));

	// One shared multiplier; only (OPERAND_WIDTH+1)-bit by (OPERAND_WIDTH+1)-bit products.
	logic signed [OPERAND_WIDTH:0] ma_n, mb_n;
	assign ma_n = mul_a[OPERAND_WIDTH:0];
	assign mb_n = mul_b[OPERAND_WIDTH:0];
	logic signed [PW-1:0] prod;
	assign prod = PW'(ma_n * mb_n);

	logic div_go_q;
	logic euclid_end;
	logic div_idle;
	assign euclid_end = (a_q == '0) || (b_q == '0);
	// The divider may be started once the previous pass has been retired.
	assign div_idle   = !dsts.busy && !div_go_q && !dsts.done;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin
				mul_a = PW'(n1_q);
				mul_b = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? $signed(k1_q)
					: (kind_q == KIND_MUL ? PW'(n2_q) : PW'(d2_q));
			end
			ST_M2: begin
				mul_a = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? PW'(n2_q) : PW'(d1_q);
				mul_b = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? $signed(k2_q)
					: (kind_q == KIND_MUL ? PW'(d2_q) : PW'(n2_q));
			end
			ST_M3: begin
				mul_a = PW'(d1_q);
				mul_b = $signed(k1_q);
			end
			default: ;
		endcase
	end

	// Divider operands follow the state.
	always_comb begin
		div_a = a_q;
		div_b = b_q;
		case (state_q)
			ST_G1, ST_G2: begin
				if (a_q > b_q) begin
					div_a = a_q;
					div_b = b_q;
				end else begin
					div_a = b_q;
					div_b = a_q;
				end
			end
			ST_K1: begin
				div_a = abs_d2;
				div_b = a_q | b_q;
			end
			ST_K2: begin
				div_a = abs_d1;
				div_b = a_q | b_q;
			end
			ST_Q1: begin
				div_a = mn_q;
				div_b = a_q | b_q;
			end
			ST_Q2: begin
				div_a = md_q;
				div_b = a_q | b_q;
			end
			default: ;
		endcase
	end

	logic out_valid_q;
	logic signed [OutWidth-1:0] rnum_q, rden_q;
	logic zdiv_q;
	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	always_comb begin
		state_d = state_q;
		dcmd.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = (first_den == '0 || second_den == '0) ? ST_DONE : ST_G1;
			end
			ST_G1, ST_G2: begin
				if (div_idle) begin
					if (euclid_end) state_d = (state_q == ST_G1) ? ST_K1 : ST_Q1;
					else dcmd.start = 1'b1;
				end
			end
			ST_K1: begin
				if (dsts.done) state_d = ST_K2;
				else if (div_idle) dcmd.start = 1'b1;
			end
			ST_K2: begin
				if (dsts.done) state_d = ST_M1;
				else if (div_idle) dcmd.start = 1'b1;
			end
			ST_Q1: begin
				if (dsts.done) state_d = ST_Q2;
				else if (div_idle) dcmd.start = 1'b1;
			end
			ST_Q2: begin
				if (dsts.done) state_d = ST_DONE;
				else if (div_idle) dcmd.start = 1'b1;
			end
			ST_M1: state_d = ST_M2;
			ST_M2: state_d = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? ST_M3 : ST_SUM;
			ST_M3: state_d = ST_SUM;
			ST_SUM: state_d = (rd_q == '0) ? ST_DONE : ST_G2;
			ST_DONE: if (out_acc) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			div_go_q    <= dcmd.start;
			out_valid_q <= (state_d == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			kind_q <= kind_t'(kind);
			n1_q   <= first_num;
			d1_q   <= first_den;
			n2_q   <= second_num;
			d2_q   <= second_den;
			a_q    <= (first_den[OPERAND_WIDTH-1] ? PW'(-PW'(first_den))
				: PW'($unsigned(first_den)));
			b_q    <= (second_den[OPERAND_WIDTH-1] ? PW'(-PW'(second_den))
				: PW'($unsigned(second_den)));
			zdiv_q <= (first_den == '0 || second_den == '0);
			rnum_q <= '0;
			rden_q <= OutWidth'(1);
		end
		if (dsts.done) begin
			case (state_q)
				ST_G1, ST_G2: begin
					if (a_q > b_q) a_q <= rem;
					else b_q <= rem;
				end
				ST_K1: k1_q <= quo;
				ST_K2: k2_q <= (d1_q[OPERAND_WIDTH-1] ^ d2_q[OPERAND_WIDTH-1]) ? -quo : quo;
				ST_Q1: rnum_q <= OutWidth'(rn_q[PW-1] ? -quo : quo);
				ST_Q2: begin
					rden_q <= OutWidth'(rd_q[PW-1] ? -quo : quo);
					zdiv_q <= 1'b0;
				end
				default: ;
			endcase
		end
		case (state_q)
			ST_M1: t_q <= prod;
			ST_M2: begin
				if (kind_q == KIND_ADD) rn_q <= t_q + prod;
				else if (kind_q == KIND_SUB) rn_q <= t_q - prod;
				else begin
					rn_q <= t_q;
					rd_q <= prod;
				end
			end
			ST_M3: rd_q <= prod;
			ST_SUM: begin
				mn_q <= rn_q[PW-1] ? PW'(-rn_q) : PW'(rn_q);
				md_q <= rd_q[PW-1] ? PW'(-rd_q) : PW'(rd_q);
				a_q  <= rn_q[PW-1] ? PW'(-rn_q) : PW'(rn_q);
				b_q  <= rd_q[PW-1] ? PW'(-rd_q) : PW'(rd_q);
				if (rd_q == '0) begin
					zdiv_q <= 1'b1;
					rnum_q <= '0;
					rden_q <= OutWidth'(1);
				end
			end
			default: ;
		endcase
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign result_num   = rnum_q;
	assign result_den   = rden_q;
	assign zero_divisor = zdiv_q;

	`RAR_ASSERT(a_valid_in_done, clk, arst_n, out_valid_q |-> state_q == ST_DONE, "valid outside done")
	`RAR_ASSERT(a_hold_stall, clk, arst_n, (out_valid_q && out_stall) |=> $stable(rnum_q) && $stable(rden_q), "result changed under stall")
	`RAR_ASSERT(a_zdiv_value, clk, arst_n, (out_valid_q && zdiv_q) |-> (rnum_q == '0 && rden_q == OutWidth'(1)), "zero divisor result not 0/1")
	`RAR_ASSERT(a_idle_divider, clk, arst_n, state_q == ST_IDLE |-> !dsts.busy, "divider busy while idle")
endmodule
`default_nettype wire

[verif/tb_rational_arith_reduce_core.sv]
// Self-checking testbench for the rational arithmetic and GCD reduction block.
module tb_rational_arith_reduce_core;
	import rar_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = OperandWidthDefault;
	localparam int N_RANDOM = 1030;

	// One expected result transaction.
	typedef struct {
		logic signed [OutWidth-1:0] num;
		logic signed [OutWidth-1:0] den;
		logic                       zdiv;
	} fraction_t;

	// One row of the directed table; has_value marks rows whose answer is typed in.
	typedef struct {
		kind_t                 op;
		logic signed [W-1:0]   a, b, c, d;
		bit                    has_value;
		longint                num, den;
		bit                    zdiv;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic signed [W-1:0] first_num = '0, first_den = '0, second_num = '0, second_den = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OutWidth-1:0] result_num, result_den;
	logic zero_divisor;

	fraction_t pending_fractions[$];
	int mismatch_count = 0;
	bit stimulus_done = 1'b0;

	rational_arith_reduce_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .first_num(first_num), .first_den(first_den),
		.second_num(second_num), .second_den(second_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_num(result_num), .result_den(result_den),
		.zero_divisor(zero_divisor)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Euclid on magnitudes.
	function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
		while (x != 0 && y != 0) begin
			if (x > y) x = x % y;
			else y = y % x;
		end
		return x + y;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Computes the reduced fraction for one operation, keeping the sign of the
	// unreduced denominator as it falls out of the arithmetic.
	function automatic fraction_t reduce_fraction(kind_t op, longint a, longint b,
			longint c, longint d);
		fraction_t r;
		longint rn, rd, k1, k2;
		longint unsigned g, mn, md;
		r.num = '0; r.den = OutWidth'(1); r.zdiv = 1'b1;
		if (b == 0 || d == 0) return r;
		case (op)
			KIND_ADD, KIND_SUB: begin
				g = gcd_mag(magnitude(b), magnitude(d));
				k1 = longint'(magnitude(d) / g);
				k2 = b / longint'(g);
				if (d < 0) k2 = -k2;
				rn = (op == KIND_ADD) ? a * k1 + c * k2 : a * k1 - c * k2;
				rd = b * k1;
			end
			KIND_MUL: begin
				rn = a * c;
				rd = b * d;
			end
			default: begin
				rn = a * d;
				rd = b * c;
			end
		endcase
		if (rd == 0) return r;
		mn = magnitude(rn);
		md = magnitude(rd);
		g = gcd_mag(mn, md);
		r.num = OutWidth'((rn < 0) ? -(mn / g) : (mn / g));
		r.den = OutWidth'((rd < 0) ? -(md / g) : (md / g));
		r.zdiv = 1'b0;
		return r;
	endfunction

	// Presents one transaction, waits for acceptance and records its expectation.
	task automatic send_fraction(kind_t op, logic signed [W-1:0] a, b, c, d, fraction_t want);
		in_valid <= 1'b1;
		kind <= op;
		first_num <= a; first_den <= b; second_num <= c; second_den <= d;
		do @(posedge clk); while (in_stall);
		pending_fractions.push_back(want);
	endtask

	function automatic logic signed [W-1:0] random_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return {1'b1, {(W-1){1'b0}}};
			2: return {1'b0, {(W-1){1'b1}}};
			3: return W'($urandom_range(0, 20)) - W'(10);
			4: return W'($urandom_range(0, 300)) - W'(150);
			default: return W'($urandom);
		endcase
	endfunction

	// Stimulus: the directed table, then random transactions in bursts.
	initial begin
		vector_t table_rows[$];
		vector_t row;
		fraction_t want;
		logic signed [W-1:0] a, b, c, d;
		kind_t op;
		int burst;
		int gap;
		bit drained;
		logic signed [W-1:0] mx, mn;
		mx = {1'b0, {(W-1){1'b1}}};
		mn = {1'b1, {(W-1){1'b0}}};
		drained = 1'b0;

		table_rows.push_back('{KIND_ADD, 1, 2, 1, 3, 1, 5, 6, 0});
		table_rows.push_back('{KIND_SUB, 1, 2, 1, 2, 1, 0, 1, 0});
		table_rows.push_back('{KIND_MUL, 2, 3, 3, 4, 1, 1, 2, 0});
		table_rows.push_back('{KIND_DIV, 1, 2, 1, 4, 1, 2, 1, 0});
		// Zero operand denominators, on each side and for every operation.
		table_rows.push_back('{KIND_ADD, 5, 0, 1, 3, 1, 0, 1, 1});
		table_rows.push_back('{KIND_SUB, 5, 3, 1, 0, 1, 0, 1, 1});
		table_rows.push_back('{KIND_MUL, 0, 0, 0, 0, 1, 0, 1, 1});
		table_rows.push_back('{KIND_DIV, 7, 0, 2, 5, 1, 0, 1, 1});
		// Division by a zero fraction yields a zero result denominator.
		table_rows.push_back('{KIND_DIV, 3, 4, 0, 5, 1, 0, 1, 1});
		// Zero numerators follow the sign of the unreduced denominator.
		table_rows.push_back('{KIND_MUL, 0, 3, 5, -7, 1, 0, -1, 0});
		table_rows.push_back('{KIND_ADD, 0, 3, 0, 5, 1, 0, 1, 0});
		table_rows.push_back('{KIND_MUL, 1, 1, 1, 1, 1, 1, 1, 0});
		// Extremes of the operand range, and mixed signs.
		table_rows.push_back('{KIND_MUL, mn, mn, mn, mn, 0, 0, 0, 0});
		table_rows.push_back('{KIND_MUL, mn, mx, mn, mx, 0, 0, 0, 0});
		table_rows.push_back('{KIND_ADD, mx, mx, mx, mn, 0, 0, 0, 0});
		table_rows.push_back('{KIND_SUB, mn, mn, mx, mx, 0, 0, 0, 0});
		table_rows.push_back('{KIND_DIV, mx, 1, mn, -1, 0, 0, 0, 0});
		table_rows.push_back('{KIND_DIV, mn, mx, mn, 3, 0, 0, 0, 0});
		table_rows.push_back('{KIND_ADD, -3, 4, 5, -6, 0, 0, 0, 0});
		table_rows.push_back('{KIND_SUB, mn, -1, mx, 1, 0, 0, 0, 0});
		table_rows.push_back('{KIND_ADD, 12, -18, -8, 12, 0, 0, 0, 0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			row = table_rows[i];
			if (row.has_value) begin
				want.num = OutWidth'(row.num);
				want.den = OutWidth'(row.den);
				want.zdiv = row.zdiv;
			end else begin
				want = reduce_fraction(row.op, row.a, row.b, row.c, row.d);
			end
			send_fraction(row.op, row.a, row.b, row.c, row.d, want);
		end

		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				op = kind_t'($urandom_range(0, 3));
				a = random_operand(); c = random_operand();
				b = random_operand(); d = random_operand();
				// Mostly valid denominators so the arithmetic path is exercised.
				if ($urandom_range(0, 9) != 0 && b == 0) b = W'($urandom_range(1, 99));
				if ($urandom_range(0, 9) != 0 && d == 0) d = W'($urandom_range(1, 99));
				send_fraction(op, a, b, c, d, reduce_fraction(op, a, b, c, d));
			end
			gap = $urandom_range(0, 6);
			if (!drained && n >= N_RANDOM / 2) begin
				// Let every outstanding result come back before continuing.
				in_valid <= 1'b0;
				drained = 1'b1;
				do @(posedge clk); while (pending_fractions.size() != 0);
			end else if (gap != 0 || n >= N_RANDOM) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		stimulus_done = 1'b1;
	end

	// Receiver stalls in runs, with long stretches of no stalling.
	initial begin
		int phase;
		@(posedge arst_n);
		forever begin
			phase = $urandom_range(0, 3);
			repeat ($urandom_range(1, 40)) begin
				@(posedge clk);
				out_stall <= (phase == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Checks each result transaction against the oldest expectation.
	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fractions.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %0d/%0d zdiv=%0b", result_num, result_den,
						zero_divisor);
			end else begin
				want = pending_fractions.pop_front();
				if (result_num !== want.num || result_den !== want.den
						|| zero_divisor !== want.zdiv) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %0d/%0d zdiv=%0b, got %0d/%0d zdiv=%0b",
							want.num, want.den, want.zdiv,
							result_num, result_den, zero_divisor);
				end
			end
		end
	end

	// Completion: drain, settle, and report.
	initial begin
		wait (stimulus_done);
		while (pending_fractions.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#100ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
